// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the isoline cell detector.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define MICD_ASSERT(lbl, clk_s, rstn_s, prop) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (prop)) \
		else $error("micd assertion failed");

// The condition must never be true at a clock edge outside reset.
`define MICD_ASSERT_NEVER(lbl, clk_s, rstn_s, cond) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) !(cond)) \
		else $error("micd forbidden condition seen");

`endif

// ===== hdl/micd_pkg.sv =====
// ----------------------------------------------------------------------------
// micd_pkg
// Types and constants shared by the isoline cell detector modules.
// ----------------------------------------------------------------------------
`default_nettype none

package micd_pkg;

	localparam int CFG_WIDTH_BITS = 11;
	localparam int LEVEL_BITS     = 16;
	localparam int CODE_BITS      = 4;
	localparam int QUEUE_DEPTH    = 4;
	localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic valid;
		logic emit;
		logic col0;
	} micd_cell_ctl_t;

	typedef struct packed {
		logic [CODE_BITS-1:0] code;
		logic                 row_end;
	} micd_result_t;

endpackage

`default_nettype wire

// ===== hdl/micd_front.sv =====
// ----------------------------------------------------------------------------
// micd_front
// Tracks the column and whether row zero is past, keeps the line buffer and
// the 2x2 window, and presents one registered cell per accepted sample.
// ----------------------------------------------------------------------------
`default_nettype none

module micd_front #(
	parameter int MAX_WIDTH   = 1024,
	parameter int SAMPLE_BITS = 16
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  accept,
	input  wire  [SAMPLE_BITS-1:0]               sample,
	input  wire                                  frame_start,
	input  wire  [micd_pkg::CFG_WIDTH_BITS-1:0]  image_width,
	output logic [SAMPLE_BITS-1:0]               tl,
	output logic [SAMPLE_BITS-1:0]               tr,
	output logic [SAMPLE_BITS-1:0]               bl,
	output logic [SAMPLE_BITS-1:0]               br,
	output micd_pkg::micd_cell_ctl_t             ctl
);
	import micd_pkg::*;

	localparam int CW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
	localparam int WW = (CFG_WIDTH_BITS > CW + 1) ? CFG_WIDTH_BITS : CW + 1;

	logic [SAMPLE_BITS-1:0] line_mem [MAX_WIDTH];
	logic [SAMPLE_BITS-1:0] rd_s1;
	logic [SAMPLE_BITS-1:0] sample_s1;
	logic                   trv_s1;
	micd_cell_ctl_t         ctl_s1;
	logic [SAMPLE_BITS-1:0] tl_q;
	logic [SAMPLE_BITS-1:0] bl_q;
	logic [CW-1:0]          col_q;
	logic                   past_q;
	logic [CW:0]            fill_q;

	logic [WW-1:0]          wcfg;
	logic [WW-1:0]          eff_w;
	logic [CW-1:0]          cc;
	logic                   past;
	logic [WW-1:0]          nxt;
	logic                   trv;

	always_comb begin
		wcfg = WW'(image_width);
		if (wcfg < WW'(2)) begin
			eff_w = WW'(2);
		end else if (wcfg > WW'(MAX_WIDTH)) begin
			eff_w = WW'(MAX_WIDTH);
		end else begin
			eff_w = wcfg;
		end
		cc   = frame_start ? '0 : col_q;
		past = frame_start ? 1'b0 : past_q;
		if (WW'(cc) >= eff_w) begin
			cc   = '0;
			past = 1'b1;
		end
		nxt = WW'(cc) + WW'(1);
		trv = {1'b0, cc} < fill_q;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			line_mem[cc] <= sample;
			rd_s1        <= line_mem[cc];
			sample_s1    <= sample;
			trv_s1       <= trv;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			past_q <= 1'b0;
			fill_q <= '0;
			ctl_s1 <= '0;
			tl_q   <= '0;
			bl_q   <= '0;
		end else begin
			ctl_s1.valid <= accept;
			if (accept) begin
				ctl_s1.emit <= past;
				ctl_s1.col0 <= (cc == '0);
				if (nxt >= eff_w) begin
					col_q  <= '0;
					past_q <= 1'b1;
				end else begin
					col_q  <= nxt[CW-1:0];
					past_q <= past;
				end
				if (!trv) begin
					fill_q <= fill_q + (CW + 1)'(1);
				end
			end
			if (ctl_s1.valid) begin
				tl_q <= tr;
				bl_q <= sample_s1;
			end
		end
	end

	assign tr  = trv_s1 ? rd_s1 : '0;
	assign tl  = tl_q;
	assign bl  = bl_q;
	assign br  = sample_s1;
	assign ctl = ctl_s1;

endmodule

`default_nettype wire

// ===== hdl/micd_classify.sv =====
// ----------------------------------------------------------------------------
// micd_classify
// Tests one cell against all contour levels and returns the first crossed one.
// ----------------------------------------------------------------------------
`default_nettype none

module micd_classify #(
	parameter int SAMPLE_BITS = 16,
	parameter int NUM_LEVELS  = 8
) (
	input  wire  [SAMPLE_BITS-1:0]           tl,
	input  wire  [SAMPLE_BITS-1:0]           tr,
	input  wire  [SAMPLE_BITS-1:0]           bl,
	input  wire  [SAMPLE_BITS-1:0]           br,
	input  wire  [micd_pkg::LEVEL_BITS-1:0]  base_level,
	input  wire  [micd_pkg::LEVEL_BITS-1:0]  level_step,
	output logic [micd_pkg::CODE_BITS-1:0]   code
);
	import micd_pkg::*;

	localparam int LVLW = LEVEL_BITS + $clog2(NUM_LEVELS) + 1;
	localparam int CMPW = (LVLW > SAMPLE_BITS) ? LVLW : SAMPLE_BITS;

	logic [NUM_LEVELS-1:0] skip;

	always_comb begin
		logic [CMPW-1:0] lvl;
		logic [CMPW-1:0] a;
		logic [CMPW-1:0] b;
		logic [CMPW-1:0] c;
		logic [CMPW-1:0] d;
		a = CMPW'(tl);
		b = CMPW'(tr);
		c = CMPW'(bl);
		d = CMPW'(br);
		for (int i = 0; i < NUM_LEVELS; i++) begin
			lvl = CMPW'(base_level) + CMPW'(level_step) * CMPW'(i);
			if (a > lvl) begin
				skip[i] = (b > lvl) && (c > lvl) && (d > lvl);
			end else begin
				skip[i] = (b < lvl) && (c < lvl) && (d < lvl);
			end
		end
	end

	always_comb begin
		code = '0;
		for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
			if (!skip[i]) begin
				code = CODE_BITS'(i + 1);
			end
		end
	end

endmodule

`default_nettype wire

// ===== hdl/micd_queue.sv =====
// ----------------------------------------------------------------------------
// micd_queue
// Short result queue between the cell pipeline and the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module micd_queue (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  push,
	input  wire  micd_pkg::micd_result_t         push_data,
	input  wire                                  pop,
	output micd_pkg::micd_result_t               head,
	output logic [micd_pkg::QUEUE_CNT_BITS-1:0]  count
);
	import micd_pkg::*;

	localparam int PW = $clog2(QUEUE_DEPTH);

	micd_result_t               slot_q [QUEUE_DEPTH];
	logic [PW-1:0]              wr_q;
	logic [PW-1:0]              rd_q;
	logic [QUEUE_CNT_BITS-1:0]  cnt_q;
	logic                       do_pop;

	assign do_pop = pop && (cnt_q != '0);

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + PW'(1);
			end
			if (do_pop) begin
				rd_q <= rd_q + PW'(1);
			end
			cnt_q <= cnt_q + QUEUE_CNT_BITS'(push) - QUEUE_CNT_BITS'(do_pop);
		end
	end

	assign head  = slot_q[rd_q];
	assign count = cnt_q;

endmodule

`default_nettype wire

// ===== hdl/multilevel_isoline_cell_detect_unit.sv =====
// ----------------------------------------------------------------------------
// multilevel_isoline_cell_detect_unit
// Marching-squares style multilevel isoline detector for a raster pixel stream.
// ----------------------------------------------------------------------------
// Pixels enter on the s_ stream in raster order, one per transfer, with
// s_tuser marking the first pixel of a frame. From the second row on, each
// pixel produces one result transfer on the m_ stream: the crossing code of
// the cell to its upper left, or a zero code with m_tlast set for the
// right-border column when the pixel is at column zero. Row zero produces no
// results and the bottom border row is not sent.
// A new pixel can be taken every cycle while s_tready is high. A result passes
// the registered line buffer read and then the queue entry on its way to m_.
// A four-entry result queue sits behind the cell stage; s_tready drops when
// the queued results and one being pushed would fill it, even during a pop.
// After reset the line buffer reads as zero: a fill count marks the entries
// written so far, so no clearing pass is run and pixels are taken at once.
// The APB port holds image_width, base_level and level_step at byte addresses
// 0, 4 and 8; write it only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module multilevel_isoline_cell_detect_unit #(
	parameter int MAX_WIDTH   = 1024,
	parameter int SAMPLE_BITS = 16,
	parameter int NUM_LEVELS  = 8
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 s_tvalid,
	output logic                                s_tready,
	input  wire  [((SAMPLE_BITS+7)/8)*8-1:0]    s_tdata,   // sample
	input  wire  [0:0]                          s_tuser,   // frame_start
	output logic                                m_tvalid,
	input  wire                                 m_tready,
	output logic [7:0]                          m_tdata,   // level_code
	output logic                                m_tlast,
	input  wire                                 psel,
	input  wire                                 penable,
	input  wire                                 pwrite,
	input  wire  [3:0]                          paddr,
	input  wire  [31:0]                         pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready
);
	import micd_pkg::*;

	typedef enum logic [1:0] {
		REG_IMAGE_WIDTH = 2'd0,
		REG_BASE_LEVEL  = 2'd1,
		REG_LEVEL_STEP  = 2'd2
	} reg_idx_t;

	localparam logic [CFG_WIDTH_BITS-1:0] RST_WIDTH = CFG_WIDTH_BITS'(640);
	localparam logic [LEVEL_BITS-1:0]     RST_BASE  = LEVEL_BITS'(4424);
	localparam logic [LEVEL_BITS-1:0]     RST_STEP  = LEVEL_BITS'(8192);

	logic [CFG_WIDTH_BITS-1:0]  image_width_q;
	logic [LEVEL_BITS-1:0]      base_level_q;
	logic [LEVEL_BITS-1:0]      level_step_q;
	logic                       cfg_wr;

	logic                       in_accept;
	logic [SAMPLE_BITS-1:0]     tl;
	logic [SAMPLE_BITS-1:0]     tr;
	logic [SAMPLE_BITS-1:0]     bl;
	logic [SAMPLE_BITS-1:0]     br;
	micd_cell_ctl_t             cell_ctl;
	logic [CODE_BITS-1:0]       cell_code;
	micd_result_t               push_data;
	logic                       push;
	logic                       pop;
	micd_result_t               head;
	logic [QUEUE_CNT_BITS-1:0]  q_count;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q <= RST_WIDTH;
			base_level_q  <= RST_BASE;
			level_step_q  <= RST_STEP;
		end else if (cfg_wr) begin
			unique case (reg_idx_t'(paddr[3:2]))
				REG_IMAGE_WIDTH: image_width_q <= pwdata[CFG_WIDTH_BITS-1:0];
				REG_BASE_LEVEL:  base_level_q  <= pwdata[LEVEL_BITS-1:0];
				REG_LEVEL_STEP:  level_step_q  <= pwdata[LEVEL_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx_t'(paddr[3:2]))
			REG_IMAGE_WIDTH: prdata = 32'(image_width_q);
			REG_BASE_LEVEL:  prdata = 32'(base_level_q);
			REG_LEVEL_STEP:  prdata = 32'(level_step_q);
			default:         prdata = '0;
		endcase
	end

	assign push     = cell_ctl.valid && cell_ctl.emit;
	assign s_tready = (q_count + QUEUE_CNT_BITS'(push)) < QUEUE_CNT_BITS'(QUEUE_DEPTH);
	assign in_accept = s_tvalid && s_tready;

	micd_front #(
		.MAX_WIDTH   (MAX_WIDTH),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (in_accept),
		.sample      (s_tdata[SAMPLE_BITS-1:0]),
		.frame_start (s_tuser[0]),
		.image_width (image_width_q),
		.tl          (tl),
		.tr          (tr),
		.bl          (bl),
		.br          (br),
		.ctl         (cell_ctl)
	);

	micd_classify #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.NUM_LEVELS  (NUM_LEVELS)
	) u_classify (
		.tl         (tl),
		.tr         (tr),
		.bl         (bl),
		.br         (br),
		.base_level (base_level_q),
		.level_step (level_step_q),
		.code       (cell_code)
	);

	assign push_data.code    = cell_ctl.col0 ? '0 : cell_code;
	assign push_data.row_end = cell_ctl.col0;

	micd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.count     (q_count)
	);

	assign m_tvalid = (q_count != '0);
	assign pop      = m_tvalid && m_tready;
	assign m_tdata  = 8'(head.code);
	assign m_tlast  = head.row_end;

	`MICD_ASSERT(a_queue_bound, clk, arst_n, q_count <= QUEUE_CNT_BITS'(QUEUE_DEPTH))
	`MICD_ASSERT_NEVER(a_no_overflow, clk, arst_n, push && (q_count == 3'd4) && !pop)
	`MICD_ASSERT(a_border_zero, clk, arst_n, (m_tvalid && m_tlast) |-> (m_tdata == 8'd0))
	`MICD_ASSERT(a_frame_start_silent, clk, arst_n, (in_accept && s_tuser[0]) |=> !push)

endmodule

`default_nettype wire
